@@ hdl/smat_pkg.sv @@
// ----------------------------------------------------------------------------
// smat_pkg
// Shared widths, register codes and types for the scaled moving average
// threshold block.
// ----------------------------------------------------------------------------
package smat_pkg;

    localparam int DEPTH      = 10;
    localparam int SLOT_W     = $clog2(DEPTH);
    localparam int DEPTH_LOG  = $clog2(DEPTH);

    localparam int SAMPLE_W   = 16;
    localparam int PROD_W     = 32;                 // sample * gain fits in 32 signed
    localparam int BIAS_W     = PROD_W + 1;         // after the offset add
    localparam int DELTA_W    = SAMPLE_W + 1;       // new entry minus old entry
    localparam int SUM_W      = SAMPLE_W + DEPTH_LOG;

    // divide by DEPTH as multiply by ceil(2^DIV_SHIFT / DEPTH), exact for |sum| < 2^SUM_W
    localparam int DIV_SHIFT  = SUM_W + DEPTH_LOG;
    localparam int RECIP_W    = SUM_W + 2;
    localparam longint unsigned RECIP = ((64'd1 << DIV_SHIFT) + DEPTH - 1) / DEPTH;
    localparam int DPROD_W    = SUM_W + RECIP_W;
    localparam int Q_W        = SAMPLE_W + 1;

    localparam logic signed [BIAS_W-1:0] SAT_HI = BIAS_W'(32767);
    localparam logic signed [BIAS_W-1:0] SAT_LO = BIAS_W'(-32768);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_SHIFT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_THR    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_THR    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_EN     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_EN     = 3'd6;

    localparam logic [15:0] GAIN_RST       = 16'd32768;
    localparam logic [4:0]  GAIN_SHIFT_RST = 5'd15;

    typedef struct packed {
        logic [15:0]        gain;
        logic [4:0]         gain_shift;
        logic signed [15:0] offset;
        logic signed [15:0] min_threshold;
        logic signed [15:0] max_threshold;
        logic               min_enable;
        logic               max_enable;
    } t_cfg;

endpackage

@@ hdl/smat_if.sv @@
// ----------------------------------------------------------------------------
// smat_if
// Valid/ready channels of the block: sample in, result out, register writes.
// ----------------------------------------------------------------------------
interface smat_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface smat_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] average;
    logic               fell_below;
    logic               rose_above;

    modport source (output valid, output average, output fell_below, output rose_above,
                    input ready);
    modport sink   (input valid, input average, input fell_below, input rose_above,
                    output ready);
endinterface

interface smat_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hdl/scaled_moving_average_threshold_top.sv @@
// ----------------------------------------------------------------------------
// scaled_moving_average_threshold_top
// Scales each sample, keeps a moving average over the last DEPTH values and
// flags threshold crossings.
// ----------------------------------------------------------------------------
// Each sample is multiplied by gain, shifted right arithmetically by
// gain_shift, offset and saturated to 16 bits, then replaces the oldest of
// DEPTH entries in a ring memory (entries read as zero until first written).
// One result leaves per sample: the window average truncated toward zero and
// the fell_below / rose_above crossing flags against the previous average.
// The block takes one sample per clock while the output is not stalled; a
// result passes through the pipeline multiply, ring read-modify-write, sum,
// reciprocal divide and output register. Ring reads are issued at the input
// transfer and written back one stage later, so successive samples never
// touch the same entry in flight. Register writes are taken every cycle and
// must only be issued while no result is pending.
// ----------------------------------------------------------------------------
module scaled_moving_average_threshold_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    smat_cfg_if.sink   i_cfg,
    smat_in_if.sink    i_in,
    smat_out_if.source o_out
);
    import smat_pkg::*;

    t_cfg                      w_cfg;
    logic                      w_ring_valid;
    logic signed [DELTA_W-1:0] w_ring_delta;
    logic                      w_avg_ready;

    smat_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    smat_ring u_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cfg   (w_cfg),
        .o_valid (w_ring_valid),
        .o_delta (w_ring_delta),
        .i_ready (w_avg_ready)
    );

    smat_avg u_avg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_valid (w_ring_valid),
        .i_delta (w_ring_delta),
        .o_ready (w_avg_ready),
        .o_out   (o_out)
    );

endmodule

@@ hdl/smat_cfg.sv @@
// ----------------------------------------------------------------------------
// smat_cfg
// Configuration register file; at most one register written per transfer.
// ----------------------------------------------------------------------------
module smat_cfg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    smat_cfg_if.sink      i_cfg,
    output smat_pkg::t_cfg o_cfg
);
    import smat_pkg::*;

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain          <= GAIN_RST;
            r_cfg.gain_shift    <= GAIN_SHIFT_RST;
            r_cfg.offset        <= '0;
            r_cfg.min_threshold <= '0;
            r_cfg.max_threshold <= '0;
            r_cfg.min_enable    <= 1'b0;
            r_cfg.max_enable    <= 1'b0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_GAIN:       r_cfg.gain          <= i_cfg.data;
                REG_GAIN_SHIFT: r_cfg.gain_shift    <= i_cfg.data[4:0];
                REG_OFFSET:     r_cfg.offset        <= $signed(i_cfg.data);
                REG_MIN_THR:    r_cfg.min_threshold <= $signed(i_cfg.data);
                REG_MAX_THR:    r_cfg.max_threshold <= $signed(i_cfg.data);
                REG_MIN_EN:     r_cfg.min_enable    <= i_cfg.data[0];
                REG_MAX_EN:     r_cfg.max_enable    <= i_cfg.data[0];
                default: begin
                end
            endcase
        end
    end

endmodule

@@ hdl/smat_ring.sv @@
// ----------------------------------------------------------------------------
// smat_ring
// Gain multiply, shift/offset/saturate, and the sample ring memory. Emits the
// change to the window sum (new entry minus the entry it replaces).
// ----------------------------------------------------------------------------
module smat_ring (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    smat_in_if.sink                               i_in,
    input  smat_pkg::t_cfg                        i_cfg,
    output logic                                  o_valid,
    output logic signed [smat_pkg::DELTA_W-1:0]   o_delta,
    input  logic                                  i_ready
);
    import smat_pkg::*;

    logic [SAMPLE_W-1:0]         r_mem [DEPTH];
    logic [DEPTH-1:0]            r_vld;         // entry written since reset
    logic [SLOT_W-1:0]           r_slot;
    logic                        r_a_vld;
    logic [SLOT_W-1:0]           r_a_slot;
    logic signed [PROD_W-1:0]    r_a_prod;
    logic [SAMPLE_W-1:0]         r_rd_data;
    logic                        r_rd_vld;
    logic                        r_b_vld;
    logic signed [DELTA_W-1:0]   r_b_delta;

    logic                        w_acc;
    logic                        w_a_adv;
    logic                        w_b_free;
    logic signed [2*Q_W-1:0]     w_prod;
    logic signed [PROD_W-1:0]    w_shift;
    logic signed [BIAS_W-1:0]    w_biased;
    logic signed [SAMPLE_W-1:0]  w_scaled;
    logic signed [SAMPLE_W-1:0]  w_old;
    logic signed [DELTA_W-1:0]   w_delta;

    assign w_b_free    = !r_b_vld || i_ready;
    assign w_a_adv     = r_a_vld && w_b_free;
    assign i_in.ready  = !r_a_vld || w_b_free;
    assign w_acc       = i_in.valid && i_in.ready;

    assign w_prod   = $signed({i_in.sample[SAMPLE_W-1], i_in.sample}) *
                      $signed({1'b0, i_cfg.gain});
    assign w_shift  = r_a_prod >>> i_cfg.gain_shift;
    assign w_biased = $signed({w_shift[PROD_W-1], w_shift}) +
                      $signed({{(BIAS_W-SAMPLE_W){i_cfg.offset[SAMPLE_W-1]}}, i_cfg.offset});

    always_comb begin
        if (w_biased > SAT_HI) begin
            w_scaled = SAT_HI[SAMPLE_W-1:0];
        end else if (w_biased < SAT_LO) begin
            w_scaled = SAT_LO[SAMPLE_W-1:0];
        end else begin
            w_scaled = w_biased[SAMPLE_W-1:0];
        end
    end

    // unwritten entries count as zero
    assign w_old   = r_rd_vld ? $signed(r_rd_data) : '0;
    assign w_delta = $signed({w_scaled[SAMPLE_W-1], w_scaled}) -
                     $signed({w_old[SAMPLE_W-1], w_old});

    assign o_valid = r_b_vld;
    assign o_delta = r_b_delta;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot  <= '0;
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_vld   <= '0;
        end else begin
            if (w_acc) begin
                r_slot <= (r_slot == SLOT_W'(DEPTH - 1)) ? '0 : r_slot + 1'b1;
            end
            if (i_in.ready) begin
                r_a_vld <= i_in.valid;
            end
            if (w_b_free) begin
                r_b_vld <= w_a_adv;
            end
            if (w_a_adv) begin
                r_vld[r_a_slot] <= 1'b1;
            end
        end
    end

    // ring read at accept, write-back as the item leaves stage A
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_rd_data <= r_mem[r_slot];
        end
        if (w_a_adv) begin
            r_mem[r_a_slot] <= w_scaled;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_a_prod <= $signed(w_prod[PROD_W-1:0]);
            r_a_slot <= r_slot;
            r_rd_vld <= r_vld[r_slot];
        end
        if (w_a_adv) begin
            r_b_delta <= w_delta;
        end
    end

`ifndef SYNTHESIS
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot <= SLOT_W'(DEPTH - 1))
        else $error("ring slot out of range");

    // a read never targets the entry whose write-back is still pending
    a_no_raw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && r_a_vld) |-> (r_a_slot != r_slot))
        else $error("ring read overlaps pending write");

    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> r_a_vld)
        else $error("accepted sample lost at stage A");
`endif

endmodule

@@ hdl/smat_avg.sv @@
// ----------------------------------------------------------------------------
// smat_avg
// Running window sum, divide by DEPTH toward zero, threshold crossing events
// and the output register.
// ----------------------------------------------------------------------------
module smat_avg (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  smat_pkg::t_cfg                        i_cfg,
    input  logic                                  i_valid,
    input  logic signed [smat_pkg::DELTA_W-1:0]   i_delta,
    output logic                                  o_ready,
    smat_out_if.source                            o_out
);
    import smat_pkg::*;

    logic signed [SUM_W-1:0]     r_sum;
    logic                        r_c_vld;
    logic signed [SUM_W-1:0]     r_c_sum;
    logic                        r_d_vld;
    logic [Q_W-1:0]              r_d_q;
    logic                        r_d_neg;
    logic                        r_e_vld;
    logic signed [SAMPLE_W-1:0]  r_e_avg;
    logic                        r_e_fell;
    logic                        r_e_rose;
    logic signed [SAMPLE_W-1:0]  r_prev;

    logic                        w_e_free;
    logic                        w_d_free;
    logic                        w_c_free;
    logic                        w_in_acc;
    logic                        w_d_adv;
    logic signed [SUM_W-1:0]     w_new_sum;
    logic [SUM_W-1:0]            w_mag;
    logic [DPROD_W-1:0]          w_div_prod;
    logic [Q_W-1:0]              w_q_signed;
    logic signed [SAMPLE_W-1:0]  w_avg;
    logic                        w_fell;
    logic                        w_rose;

    assign w_e_free = !r_e_vld || o_out.ready;
    assign w_d_free = !r_d_vld || w_e_free;
    assign w_c_free = !r_c_vld || w_d_free;
    assign o_ready  = w_c_free;
    assign w_in_acc = i_valid && w_c_free;
    assign w_d_adv  = r_d_vld && w_e_free;

    assign w_new_sum = r_sum + SUM_W'(i_delta);

    // magnitude times reciprocal; sign applied after the shift gives truncation toward zero
    assign w_mag      = r_c_sum[SUM_W-1] ? $unsigned(-r_c_sum) : $unsigned(r_c_sum);
    assign w_div_prod = DPROD_W'(w_mag) * DPROD_W'(RECIP);

    assign w_q_signed = r_d_neg ? (~r_d_q + 1'b1) : r_d_q;
    assign w_avg      = $signed(w_q_signed[SAMPLE_W-1:0]);
    assign w_fell     = i_cfg.min_enable && (w_avg < i_cfg.min_threshold) &&
                        (r_prev >= i_cfg.min_threshold);
    assign w_rose     = i_cfg.max_enable && (w_avg > i_cfg.max_threshold) &&
                        (r_prev <= i_cfg.max_threshold);

    assign o_out.valid      = r_e_vld;
    assign o_out.average    = r_e_avg;
    assign o_out.fell_below = r_e_fell;
    assign o_out.rose_above = r_e_rose;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_prev  <= '0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
            r_e_vld <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_sum <= w_new_sum;
            end
            if (w_d_adv) begin
                r_prev <= w_avg;
            end
            if (w_c_free) begin
                r_c_vld <= i_valid;
            end
            if (w_d_free) begin
                r_d_vld <= r_c_vld;
            end
            if (w_e_free) begin
                r_e_vld <= r_d_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_c_sum <= w_new_sum;
        end
        if (r_c_vld && w_d_free) begin
            r_d_q   <= w_div_prod[DIV_SHIFT +: Q_W];
            r_d_neg <= r_c_sum[SUM_W-1];
        end
        if (w_d_adv) begin
            r_e_avg  <= w_avg;
            r_e_fell <= w_fell;
            r_e_rose <= w_rose;
        end
    end

`ifndef SYNTHESIS
    // previous average cannot be both >= min and <= max when min > max
    a_one_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_e_vld && r_e_fell && r_e_rose))
        else $error("both crossing events on one result");

    a_rose_en: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_e_vld && r_e_rose) |-> i_cfg.max_enable)
        else $error("rise event while disabled");

    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> r_c_vld)
        else $error("sum stage dropped a transfer");
`endif

endmodule

@@ tb/scaled_moving_average_threshold_top_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scaled_moving_average_threshold_top_test
// Self-checking bench for the scaled moving average threshold block: a short
// directed table (reset window, scaling extremes, saturation, register edge
// cases, crossing events) then randomized register settings and sample streams,
// checked against table values or an in-bench model of the scaled window average.
// ----------------------------------------------------------------------------
module scaled_moving_average_threshold_top_test;
    import smat_pkg::*;

    localparam int PIPE_LAT    = 4;
    localparam int CYCLE_LIMIT = 500000;
    localparam int NUM_PHASES  = 18;
    localparam int PHASE_ITEMS = 74;

    // index past the last register, writes to it must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef struct packed {
        logic signed [15:0] average;
        logic               fell_below;
        logic               rose_above;
    } t_avg_result;

    typedef enum logic {ROW_CFG, ROW_SAMPLE} t_row_kind;

    typedef struct {
        t_row_kind              kind;
        logic [CFG_IDX_W-1:0]   idx;
        logic [15:0]            data;
        bit                     typed;
        t_avg_result            want;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;

    smat_cfg_if cfg_ch ();
    smat_in_if  in_ch ();
    smat_out_if out_ch ();

    scaled_moving_average_threshold_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // shadow of the block's registers and window
    t_cfg               shadow_cfg;
    logic signed [15:0] shadow_ring [DEPTH];
    int                 next_slot;
    int                 ring_total;
    int                 last_avg;

    t_avg_result pending_results [$];
    t_stim_row   stim_table [$];

    int error_count;
    int cycle_count;
    bit quiet_phase;

    // random stream state: runs around a level so the average really moves
    int run_left;
    int run_level;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // -------------------------------------------------------------- model
    function automatic logic signed [15:0] apply_gain(logic signed [15:0] raw);
        longint prod;
        longint q;
        prod = longint'(raw) * longint'({1'b0, shadow_cfg.gain});
        q = (prod >>> shadow_cfg.gain_shift) + longint'($signed(shadow_cfg.offset));
        if (q > 32767)
            q = 32767;
        if (q < -32768)
            q = -32768;
        return q[15:0];
    endfunction

    function automatic t_avg_result advance_window(logic signed [15:0] raw);
        logic signed [15:0] v;
        int                 avg;
        int                 lo_thr;
        int                 hi_thr;
        t_avg_result        r;
        v = apply_gain(raw);
        ring_total = ring_total - int'(shadow_ring[next_slot]) + int'(v);
        shadow_ring[next_slot] = v;
        next_slot = (next_slot + 1 >= DEPTH) ? 0 : next_slot + 1;
        avg = ring_total / DEPTH;
        lo_thr = int'($signed(shadow_cfg.min_threshold));
        hi_thr = int'($signed(shadow_cfg.max_threshold));
        r.average    = avg[15:0];
        r.fell_below = shadow_cfg.min_enable && avg < lo_thr && last_avg >= lo_thr;
        r.rose_above = shadow_cfg.max_enable && avg > hi_thr && last_avg <= hi_thr;
        last_avg = avg;
        return r;
    endfunction

    function automatic void note_reg_write(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
        case (idx)
            REG_GAIN:       shadow_cfg.gain          = data;
            REG_GAIN_SHIFT: shadow_cfg.gain_shift    = data[4:0];
            REG_OFFSET:     shadow_cfg.offset        = data;
            REG_MIN_THR:    shadow_cfg.min_threshold = data;
            REG_MAX_THR:    shadow_cfg.max_threshold = data;
            REG_MIN_EN:     shadow_cfg.min_enable    = data[0];
            REG_MAX_EN:     shadow_cfg.max_enable    = data[0];
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------ checker
    always @(posedge i_clk) begin
        t_avg_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual average %0d",
                         $time, $signed(out_ch.average));
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (out_ch.average !== want.average) begin
                    $display("%0t: average mismatch, expected %0d, actual %0d",
                             $time, $signed(want.average), $signed(out_ch.average));
                    error_count++;
                end
                if (out_ch.fell_below !== want.fell_below) begin
                    $display("%0t: fell_below mismatch, expected %0b, actual %0b",
                             $time, want.fell_below, out_ch.fell_below);
                    error_count++;
                end
                if (out_ch.rose_above !== want.rose_above) begin
                    $display("%0t: rose_above mismatch, expected %0b, actual %0b",
                             $time, want.rose_above, out_ch.rose_above);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------ idling
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_phase || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(negedge i_clk) begin
        int stall_left;
        if (stall_left > 0) begin
            out_ch.ready <= 1'b0;
            stall_left--;
        end else begin
            out_ch.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                stall_left = pick_gap();
        end
    end

    // ------------------------------------------------------------ drivers
    // all driver tasks start and end on a falling edge
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (PIPE_LAT) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
        wait_idle();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (!(cfg_ch.valid && cfg_ch.ready));
        note_reg_write(idx, data);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic send_sample(logic signed [15:0] raw, bit typed, t_avg_result want);
        int          gap;
        t_avg_result got;
        gap = pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.sample <= raw;
        do @(posedge i_clk); while (!(in_ch.valid && in_ch.ready));
        got = advance_window(raw);
        pending_results.push_back(typed ? want : got);
        @(negedge i_clk);
    endtask

    // ------------------------------------------------------ directed table
    function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
        t_stim_row row;
        row.kind  = ROW_CFG;
        row.idx   = idx;
        row.data  = data;
        row.typed = 1'b0;
        row.want  = '0;
        stim_table.push_back(row);
    endfunction

    function automatic void add_sample(logic [15:0] raw);
        t_stim_row row;
        row.kind  = ROW_SAMPLE;
        row.idx   = '0;
        row.data  = raw;
        row.typed = 1'b0;
        row.want  = '0;
        stim_table.push_back(row);
    endfunction

    function automatic void add_checked(logic [15:0] raw, int avg, bit fell, bit rose);
        t_stim_row row;
        row.kind  = ROW_SAMPLE;
        row.idx   = '0;
        row.data  = raw;
        row.typed = 1'b1;
        row.want.average    = avg[15:0];
        row.want.fell_below = fell;
        row.want.rose_above = rose;
        stim_table.push_back(row);
    endfunction

    function automatic void build_table();
        // reset gain is unity, so the window is the raw samples over cleared entries
        add_checked(16'h7FFF, 3276, 1'b0, 1'b0);
        add_checked(16'h8000, 0, 1'b0, 1'b0);
        add_checked(16'h8000, -3276, 1'b0, 1'b0);
        add_checked(16'h0000, -3276, 1'b0, 1'b0);
        add_cfg(REG_UNUSED, 16'h1234);
        add_checked(16'h0000, -3276, 1'b0, 1'b0);
        // largest gain, no shift, top offset: saturation both ways
        add_cfg(REG_GAIN, 16'hFFFF);
        add_cfg(REG_GAIN_SHIFT, 16'h0000);
        add_cfg(REG_OFFSET, 16'h7FFF);
        add_sample(16'h7FFF);
        add_sample(16'h8000);
        add_sample(16'h0001);
        add_sample(16'hFFFF);
        add_sample(16'h0000);
        // shift register keeps only its low bits: 31
        add_cfg(REG_GAIN_SHIFT, 16'hFFFF);
        add_cfg(REG_OFFSET, 16'h8000);
        add_sample(16'h8000);
        add_sample(16'h7FFF);
        add_cfg(REG_GAIN, 16'h0000);
        add_sample(16'h3039);
        // unity gain, both crossing events armed
        add_cfg(REG_GAIN, GAIN_RST);
        add_cfg(REG_GAIN_SHIFT, 16'(GAIN_SHIFT_RST));
        add_cfg(REG_OFFSET, 16'h0000);
        add_cfg(REG_MIN_THR, 16'hFF9C);
        add_cfg(REG_MAX_THR, 16'h0064);
        add_cfg(REG_MIN_EN, 16'h0001);
        add_cfg(REG_MAX_EN, 16'h0001);
        for (int i = 0; i < 3; i++)
            add_sample(16'h7FFF);
        for (int i = 0; i < 4; i++)
            add_sample(16'h8000);
        // enables keep only bit 0
        add_cfg(REG_MIN_EN, 16'hFFFE);
        add_cfg(REG_MAX_EN, 16'hFFFE);
        add_sample(16'h7FFF);
        add_sample(16'h8000);
    endfunction

    // ------------------------------------------------------- random part
    function automatic logic [15:0] draw_sample();
        int r;
        int v;
        r = $urandom_range(0, 99);
        if (run_left == 0) begin
            run_left  = $urandom_range(4, 30);
            run_level = int'($urandom_range(0, 65535)) - 32768;
        end
        run_left--;
        if (r < 45)
            v = run_level + int'($urandom_range(0, 1024)) - 512;
        else if (r < 70)
            v = int'($urandom_range(0, 65535)) - 32768;
        else if (r < 80)
            v = ($urandom_range(0, 1) != 0) ? 32767 : -32768;
        else
            v = int'($urandom_range(0, 512)) - 256;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v[15:0];
    endfunction

    function automatic logic [15:0] pick_level(int span);
        case ($urandom_range(0, 5))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'($urandom_range(0, 65535));
            default: return 16'(int'($urandom_range(0, 2 * span)) - span);
        endcase
    endfunction

    task automatic shuffle_regs();
        logic [15:0] d;
        for (int idx = 0; idx < 7; idx++) begin
            if ($urandom_range(0, 3) != 0) begin
                case (idx)
                    REG_GAIN: begin
                        case ($urandom_range(0, 5))
                            0:       d = 16'h0000;
                            1:       d = 16'hFFFF;
                            2:       d = 16'($urandom_range(0, 65535));
                            default: d = 16'($urandom_range(24576, 40960));
                        endcase
                    end
                    REG_GAIN_SHIFT: begin
                        case ($urandom_range(0, 5))
                            0:       d = 16'h0000;
                            1:       d = 16'd31;
                            2:       d = 16'($urandom_range(0, 65535));
                            default: d = 16'($urandom_range(14, 17));
                        endcase
                    end
                    REG_OFFSET:  d = pick_level(2000);
                    REG_MIN_THR: d = pick_level(6000);
                    REG_MAX_THR: d = pick_level(6000);
                    default:     d = 16'($urandom_range(0, 65535));
                endcase
                write_reg(idx[CFG_IDX_W-1:0], d);
            end
        end
        if ($urandom_range(0, 3) == 0)
            write_reg(REG_UNUSED, 16'($urandom_range(0, 65535)));
    endtask

    // --------------------------------------------------------------- main
    initial begin
        t_avg_result none;
        i_rst_n       = 1'b0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.index  = '0;
        cfg_ch.data   = '0;
        in_ch.valid   = 1'b0;
        in_ch.sample  = '0;
        out_ch.ready  = 1'b0;
        error_count   = 0;
        cycle_count   = 0;
        quiet_phase   = 1'b0;
        run_left      = 0;
        run_level     = 0;
        none          = '0;

        shadow_cfg               = '0;
        shadow_cfg.gain          = GAIN_RST;
        shadow_cfg.gain_shift    = GAIN_SHIFT_RST;
        for (int i = 0; i < DEPTH; i++)
            shadow_ring[i] = '0;
        next_slot  = 0;
        ring_total = 0;
        last_avg   = 0;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        build_table();
        foreach (stim_table[i]) begin
            if (stim_table[i].kind == ROW_CFG)
                write_reg(stim_table[i].idx, stim_table[i].data);
            else
                send_sample(stim_table[i].data, stim_table[i].typed, stim_table[i].want);
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            shuffle_regs();
            quiet_phase = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_sample(draw_sample(), 1'b0, none);
        end
        quiet_phase = 1'b0;

        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (PIPE_LAT * 4) @(posedge i_clk);

        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

@@ files.f @@
hdl/smat_pkg.sv
hdl/smat_if.sv
hdl/smat_cfg.sv
hdl/smat_ring.sv
hdl/smat_avg.sv
hdl/scaled_moving_average_threshold_top.sv
tb/scaled_moving_average_threshold_top_test.sv
